FILE: sv/acs_pkg.sv
// package for the accelerometer capture statistics block
// widths, state and code enums, shared structs; no dependencies
package acs_pkg;

	localparam int CNT_W      = 7;
	localparam int ELAPSED_W  = 16;
	localparam int TAG_W      = 8;
	localparam int SAMPLE_W   = 16;
	localparam int AXIS_W     = 14;
	localparam int MAG_W      = 14;
	localparam int SUM_W      = 20;
	localparam int MSUM_W     = 20;
	localparam int M2SUM_W    = 34;
	localparam int SQ_W       = 28;
	localparam int OPND_W     = 40;
	localparam int REM_W      = 23;
	localparam int RES_W      = 20;
	localparam int ITER_W     = 5;
	localparam int MUL_A_W    = 34;
	localparam int MUL_B_W    = 20;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int STEPS      = 20;
	localparam int LIMIT_MG   = 8000;
	localparam int MAX_SAMPLES = 64;

	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	localparam logic CFG_CAPTURE_COUNT = 1'b0;
	localparam logic CFG_LIMIT_MS      = 1'b1;

	localparam logic [CNT_W-1:0]     CAPTURE_COUNT_RST = 7'd20;
	localparam logic [ELAPSED_W-1:0] LIMIT_MS_RST      = 16'd2000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_MAG,
		ST_LHS,
		ST_STDROOT,
		ST_STDDIV,
		ST_MEAN,
		ST_EMIT
	} state_t;

	typedef enum logic {
		UNIT_SQRT,
		UNIT_DIV
	} unit_mode_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [RES_W-1:0]  res;
		logic [OPND_W-1:0] opnd;
	} step_t;

	typedef struct packed {
		logic [CNT_W-1:0]     capture_count;
		logic [ELAPSED_W-1:0] limit_ms;
	} cfg_t;

	typedef struct packed {
		logic [TAG_W-1:0]        result_tag;
		logic                    success;
		logic [CNT_W-1:0]        samples_seen;
		logic [ELAPSED_W-1:0]    elapsed_ms;
		logic signed [AXIS_W-1:0] mean_x;
		logic signed [AXIS_W-1:0] mean_y;
		logic signed [AXIS_W-1:0] mean_z;
		logic [MAG_W-1:0]        std_mag;
	} result_t;

endpackage

FILE: sv/accel_capture_statistics.sv
// accelerometer capture statistics, top level
// depends on acs_pkg and acs_core
//
// input stream s_*: one transaction per start request, sample or millisecond
// tick, kind in s_tuser. output stream m_*: one transaction per finished
// capture, success flag in m_tuser.
// a tick that ends a capture goes on to load the result register. a sample
// is accepted, its squared length is formed on the multiplier, 20 square root
// digits are taken on the shared compare and subtract unit and it is
// accumulated. the sample that completes a capture adds multiplier steps, the
// deviation root and divide (skipped when the variance is not positive) and
// the three mean divides on the same unit, then loads the result register.
// s_tready is high only while the sequencer is idle.
// a result waits in the output register while m_tready is low; the block
// keeps taking transactions and stalls only when a second result is ready.
// reset ends any capture, clears pending results and restores
// capture_count to 20 and the timeout to 2000.
// configuration: cfg_we with cfg_index 0 capture_count, 1 timeout in ms.
module accel_capture_statistics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // sample_x, sample_y, sample_z, request_tag
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // result_tag, samples_seen, elapsed_ms, mean_x,
	                               // mean_y, mean_z, std_mag, zero pad
	output logic [0:0]  m_tuser,   // success
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);
	import acs_pkg::*;

	cfg_t cfg_q;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capture_count <= CAPTURE_COUNT_RST;
			cfg_q.limit_ms <= LIMIT_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAPTURE_COUNT: cfg_q.capture_count <= cfg_wdata[CNT_W-1:0];
				CFG_LIMIT_MS:      cfg_q.limit_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	acs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_x      (s_tdata[15:0]),
		.in_y      (s_tdata[31:16]),
		.in_z      (s_tdata[47:32]),
		.in_tag    (s_tdata[55:48]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {1'b0, res.std_mag, res.mean_z, res.mean_y, res.mean_x,
		res.elapsed_ms, res.samples_seen, res.result_tag};
	assign m_tuser = res.success;

endmodule

FILE: sv/acs_step_unit.sv
// shared compare and subtract unit: one square root digit or one division bit
// depends on acs_pkg
module acs_step_unit (
	input  acs_pkg::unit_mode_t      mode,
	input  acs_pkg::step_t           cur,
	input  logic [acs_pkg::CNT_W-1:0] divisor,
	output acs_pkg::step_t           nxt
);
	import acs_pkg::*;

	logic [REM_W-1:0] pre;
	logic [REM_W-1:0] trial;
	logic [REM_W:0]   diff;
	logic             ge;

	always_comb begin
		if (mode == UNIT_SQRT) begin
			pre   = {cur.rem[REM_W-3:0], cur.opnd[OPND_W-1 -: 2]};
			trial = {1'b0, cur.res, 2'b01};
		end else begin
			pre   = {cur.rem[REM_W-2:0], cur.opnd[OPND_W-1]};
			trial = {{(REM_W-CNT_W){1'b0}}, divisor};
		end
		diff = {1'b0, pre} - {1'b0, trial};
		ge = !diff[REM_W];
		nxt.rem = ge ? diff[REM_W-1:0] : pre;
		nxt.res = {cur.res[RES_W-2:0], ge};
		if (mode == UNIT_SQRT)
			nxt.opnd = {cur.opnd[OPND_W-3:0], 2'b00};
		else
			nxt.opnd = {cur.opnd[OPND_W-2:0], 1'b0};
	end

endmodule

FILE: sv/acs_core.sv
// capture sequencer: accumulators, shared multiplier, result register
// depends on acs_pkg and acs_step_unit
module acs_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  acs_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        in_kind,
	input  logic signed [acs_pkg::SAMPLE_W-1:0] in_x,
	input  logic signed [acs_pkg::SAMPLE_W-1:0] in_y,
	input  logic signed [acs_pkg::SAMPLE_W-1:0] in_z,
	input  logic [acs_pkg::TAG_W-1:0]         in_tag,
	output logic                              out_valid,
	input  logic                              out_ready,
	output acs_pkg::result_t                  out_res
);
	import acs_pkg::*;

	state_t state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic [1:0] axis_q;

	logic running_q;
	logic [CNT_W-1:0] count_q;
	logic [TAG_W-1:0] tag_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic [MSUM_W-1:0] msum_q;
	logic [M2SUM_W-1:0] m2sum_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic signed [AXIS_W-1:0] v_q [3];
	logic [SQ_W-1:0] sq_q;
	logic [OPND_W-1:0] lhs_q;
	logic [PROD_W-1:0] prod_s1;
	step_t step_q, step_n;
	logic signed [AXIS_W-1:0] mean_q [3];
	logic [MAG_W-1:0] std_q;
	logic ok_q;
	logic out_valid_q;
	result_t out_q;

	unit_mode_t mode;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic accept;
	logic [ELAPSED_W-1:0] elapsed_inc;
	logic tick_fail;
	logic [CNT_W-1:0] target;
	logic [CNT_W-1:0] count_inc;
	logic last_step;
	logic slot_free;
	logic [SQ_W-1:0] sq_total;
	logic [OPND_W-1:0] rhs;
	logic signed [SAMPLE_W-1:0] raw [3];
	logic [SUM_W-1:0] abs_sum [3];
	logic [AXIS_W-1:0] abs_v [3];
	logic [RES_W-1:0] quot_neg;

	acs_step_unit u_step (
		.mode    (mode),
		.cur     (step_q),
		.divisor (count_q),
		.nxt     (step_n)
	);

	assign accept = in_valid && in_ready;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign tick_fail = elapsed_inc > cfg.limit_ms;
	assign count_inc = count_q + 1'b1;
	assign last_step = iter_q == ITER_W'(STEPS - 1);
	assign slot_free = !out_valid_q || out_ready;
	assign sq_total = sq_q + prod_s1[SQ_W-1:0];
	assign rhs = prod_s1[OPND_W-1:0];
	assign raw[0] = in_x;
	assign raw[1] = in_y;
	assign raw[2] = in_z;
	assign quot_neg = -step_n.res;

	always_comb begin
		if (cfg.capture_count == '0)
			target = CNT_W'(1);
		else if (cfg.capture_count > CNT_W'(MAX_SAMPLES))
			target = CNT_W'(MAX_SAMPLES);
		else
			target = cfg.capture_count;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_sum[i] = sum_q[i][SUM_W-1] ? SUM_W'(-sum_q[i]) : SUM_W'(sum_q[i]);
			abs_v[i] = v_q[i][AXIS_W-1] ? AXIS_W'(-v_q[i]) : AXIS_W'(v_q[i]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && running_q) begin
					if (in_kind == KIND_SAMPLE)
						state_d = ST_SQ;
					else if (in_kind == KIND_TICK && tick_fail)
						state_d = ST_EMIT;
				end
			end
			ST_SQ: begin
				if (iter_q == ITER_W'(3))
					state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (last_step)
					state_d = ST_MAG;
			end
			ST_MAG: begin
				if (iter_q == ITER_W'(1))
					state_d = (count_inc >= target) ? ST_LHS : ST_IDLE;
			end
			ST_LHS: begin
				if (iter_q == ITER_W'(2))
					state_d = (lhs_q > rhs) ? ST_STDROOT : ST_MEAN;
			end
			ST_STDROOT: begin
				if (last_step)
					state_d = ST_STDDIV;
			end
			ST_STDDIV: begin
				if (last_step)
					state_d = ST_MEAN;
			end
			ST_MEAN: begin
				if (last_step && axis_q == 2'd2)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs and multiplier operands
	always_comb begin
		in_ready = state_q == ST_IDLE;
		mode = (state_q inside {ST_STDDIV, ST_MEAN}) ? UNIT_DIV : UNIT_SQRT;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ: begin
				case (iter_q[1:0])
					2'd0: begin
						mul_a = MUL_A_W'(abs_v[0]);
						mul_b = MUL_B_W'(abs_v[0]);
					end
					2'd1: begin
						mul_a = MUL_A_W'(abs_v[1]);
						mul_b = MUL_B_W'(abs_v[1]);
					end
					2'd2: begin
						mul_a = MUL_A_W'(abs_v[2]);
						mul_b = MUL_B_W'(abs_v[2]);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			ST_MAG: begin
				mul_a = MUL_A_W'(step_q.res[MAG_W-1:0]);
				mul_b = MUL_B_W'(step_q.res[MAG_W-1:0]);
			end
			ST_LHS: begin
				if (iter_q == '0) begin
					mul_a = m2sum_q;
					mul_b = MUL_B_W'(count_q);
				end else begin
					mul_a = MUL_A_W'(msum_q);
					mul_b = msum_q;
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			running_q <= 1'b0;
			out_valid_q <= 1'b0;
			iter_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE || state_d != state_q || (state_q == ST_MEAN && last_step))
				iter_q <= '0;
			else
				iter_q <= iter_q + 1'b1;
			if (state_q == ST_IDLE && accept && in_kind == KIND_START)
				running_q <= 1'b1;
			else if (state_q == ST_EMIT && slot_free)
				running_q <= 1'b0;
			if (state_q == ST_EMIT && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_kind == KIND_START && !running_q) begin
					tag_q <= in_tag;
					count_q <= '0;
					for (int i = 0; i < 3; i++)
						sum_q[i] <= '0;
					msum_q <= '0;
					m2sum_q <= '0;
					elapsed_q <= '0;
				end
				if (accept && in_kind == KIND_SAMPLE) begin
					for (int i = 0; i < 3; i++)
						v_q[i] <= (raw[i] >= -SAMPLE_W'(LIMIT_MG) && raw[i] <= SAMPLE_W'(LIMIT_MG))
							? AXIS_W'(raw[i]) : '0;
					sq_q <= '0;
				end
				if (accept && in_kind == KIND_TICK && running_q) begin
					elapsed_q <= elapsed_inc;
					ok_q <= 1'b0;
					std_q <= '0;
					for (int i = 0; i < 3; i++)
						mean_q[i] <= '0;
				end
			end
			ST_SQ: begin
				if (iter_q != '0)
					sq_q <= sq_total;
				if (iter_q == ITER_W'(3)) begin
					step_q.opnd <= OPND_W'(sq_total);
					step_q.rem <= '0;
					step_q.res <= '0;
				end
			end
			ST_ROOT: step_q <= step_n;
			ST_MAG: begin
				if (iter_q == ITER_W'(1)) begin
					m2sum_q <= m2sum_q + M2SUM_W'(prod_s1[SQ_W-1:0]);
					msum_q <= msum_q + step_q.res;
					count_q <= count_inc;
					for (int i = 0; i < 3; i++)
						sum_q[i] <= sum_q[i] + SUM_W'(v_q[i]);
				end
			end
			ST_LHS: begin
				if (iter_q == ITER_W'(1))
					lhs_q <= prod_s1[OPND_W-1:0];
				if (iter_q == ITER_W'(2)) begin
					ok_q <= 1'b1;
					step_q.rem <= '0;
					step_q.res <= '0;
					axis_q <= '0;
					if (lhs_q > rhs) begin
						step_q.opnd <= lhs_q - rhs;
					end else begin
						std_q <= '0;
						step_q.opnd <= {abs_sum[0], {(OPND_W-SUM_W){1'b0}}};
					end
				end
			end
			ST_STDROOT: begin
				if (last_step) begin
					step_q.opnd <= {step_n.res, {(OPND_W-RES_W){1'b0}}};
					step_q.rem <= '0;
					step_q.res <= '0;
				end else begin
					step_q <= step_n;
				end
			end
			ST_STDDIV: begin
				if (last_step) begin
					std_q <= step_n.res[MAG_W-1:0];
					axis_q <= '0;
					step_q.opnd <= {abs_sum[0], {(OPND_W-SUM_W){1'b0}}};
					step_q.rem <= '0;
					step_q.res <= '0;
				end else begin
					step_q <= step_n;
				end
			end
			ST_MEAN: begin
				if (last_step) begin
					mean_q[axis_q] <= sum_q[axis_q][SUM_W-1] ? quot_neg[AXIS_W-1:0]
						: step_n.res[AXIS_W-1:0];
					axis_q <= axis_q + 1'b1;
					step_q.opnd <= (axis_q == 2'd0)
						? {abs_sum[1], {(OPND_W-SUM_W){1'b0}}}
						: {abs_sum[2], {(OPND_W-SUM_W){1'b0}}};
					step_q.rem <= '0;
					step_q.res <= '0;
				end else begin
					step_q <= step_n;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_q.result_tag <= tag_q;
					out_q.success <= ok_q;
					out_q.samples_seen <= count_q;
					out_q.elapsed_ms <= elapsed_q;
					out_q.mean_x <= mean_q[0];
					out_q.mean_y <= mean_q[1];
					out_q.mean_z <= mean_q[2];
					out_q.std_mag <= std_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_res = out_q;

endmodule

FILE: sv/acs_checker.sv
// port-level checks for accel_capture_statistics, bound to the top level
// depends on nothing but the top level's ports
module acs_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [0:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[86:31] == 56'd0)
		else $error("failed capture with nonzero statistics");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14:8] <= 7'd64)
		else $error("sample count out of range");

	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result produced while input side was idle");

endmodule

bind accel_capture_statistics acs_port_checks u_acs_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
